>>> hdl/tridiagonal_system_solver_defines.svh
// Assertion macros shared by the solver RTL.
`ifndef TRIDIAGONAL_SYSTEM_SOLVER_DEFINES_SVH
`define TRIDIAGONAL_SYSTEM_SOLVER_DEFINES_SVH

`ifndef SYNTHESIS
`define TSS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("solver check failed");
`define TSS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("solver check failed");
`else
`define TSS_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define TSS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

>>> hdl/tss_pkg.sv
package tss_pkg;

  localparam int unsigned FX_W          = 32;
  localparam int unsigned ROW_IDX_W     = 7;
  localparam int unsigned MAX_ROWS_DEF  = 64;
  localparam int unsigned FRAC_BITS_DEF = 16;

  localparam logic signed [FX_W-1:0] FX_MAX = 32'sh7fff_ffff;
  localparam logic signed [FX_W-1:0] FX_MIN = 32'sh8000_0000;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FRD,
    S_FMUL1,
    S_FDIV1S,
    S_FDIV1W,
    S_FMUL2,
    S_FDIV2S,
    S_FDIV2W,
    S_FWR,
    S_BRD,
    S_BMUL,
    S_BDIVS,
    S_BDIVW,
    S_OUT
  } tss_state_e;

  // Saturating subtract on Q-format words.
  function automatic logic signed [FX_W-1:0] sat_sub(logic signed [FX_W-1:0] p,
                                                     logic signed [FX_W-1:0] q);
    logic [FX_W:0] s;
    s = {p[FX_W-1], p} - {q[FX_W-1], q};
    if (s[FX_W] != s[FX_W-1]) begin
      return s[FX_W] ? FX_MIN : FX_MAX;
    end
    return s[FX_W-1:0];
  endfunction

endpackage

>>> hdl/tss_ram.sv
module tss_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

>>> hdl/tss_div.sv
// Restoring radix-2 divider: (num * 2^FRAC) / den, truncated toward zero,
// saturated, zero for a zero divisor. One quotient bit per cycle.
module tss_div #(
  parameter int unsigned FRAC = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic signed [tss_pkg::FX_W-1:0]     num_i,
  input  logic signed [tss_pkg::FX_W-1:0]     den_i,
  output logic                                done_o,
  output logic signed [tss_pkg::FX_W-1:0]     quot_o
);

  localparam int unsigned W  = tss_pkg::FX_W;
  localparam int unsigned QW = W + FRAC;
  localparam int unsigned CW = $clog2(QW + 1);

  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [W-1:0]  rem_q;
  logic [QW-1:0] quo_q;
  logic [W-1:0]  den_q;
  logic          neg_q, zero_q;
  logic signed [W-1:0] res_q;

  logic [W:0]    rem_sh;
  logic [W-1:0]  rem_nx;
  logic          ge;
  logic [QW-1:0] quo_nx;
  logic [W-1:0]  num_abs, den_abs;
  logic          last_step;
  logic signed [W-1:0] res_nx;

  always_comb begin
    num_abs   = num_i[W-1] ? W'(-num_i) : W'(num_i);
    den_abs   = den_i[W-1] ? W'(-den_i) : W'(den_i);
    // The partial remainder stays below the divisor, so it fits in W bits.
    rem_sh    = {rem_q, quo_q[QW-1]};
    ge        = rem_sh >= {1'b0, den_q};
    rem_nx    = ge ? W'(rem_sh - {1'b0, den_q}) : rem_sh[W-1:0];
    quo_nx    = {quo_q[QW-2:0], ge};
    last_step = busy_q && (cnt_q == CW'(QW - 1));
    if (zero_q) begin
      res_nx = '0;
    end else if (neg_q) begin
      res_nx = (quo_nx > QW'(33'h0_8000_0000)) ? tss_pkg::FX_MIN : W'(-quo_nx);
    end else begin
      res_nx = (quo_nx > QW'(33'h0_7fff_ffff)) ? tss_pkg::FX_MAX : W'(quo_nx);
    end
    busy_d = busy_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
    end else if (busy_q) begin
      cnt_d = cnt_q + CW'(1);
      if (last_step) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= '0;
      quo_q  <= {num_abs, FRAC'(0)};
      den_q  <= den_abs;
      neg_q  <= num_i[W-1] ^ den_i[W-1];
      zero_q <= (den_i == '0);
    end else if (busy_q) begin
      rem_q <= rem_nx;
      quo_q <= quo_nx;
      if (last_step) begin
        res_q <= res_nx;
      end
    end
  end

  assign done_o = done_q;
  assign quot_o = res_q;

endmodule

>>> hdl/tridiagonal_system_solver.sv
// Channel | Direction | Handshake                 | Payload
// in      | input     | in_valid_i / in_ready_o   | sub_diag, main_diag, super_diag,
//         |           |                           | rhs_value, last_row
// out     | output    | out_valid_o / out_ready_i | row_index, solution, singular,
//         |           |                           | last_result
//
// The first row of a system is written to the stores straight after it is taken;
// every later row makes two passes through the one shared divider, which produces
// one quotient bit per cycle.
// The final row then yields one item per row, each after a back-substitution
// division and any stall on out_ready_i; no new row is taken until row one is out.
// Reset (rst_ni low, asynchronous) clears the row count and the singular flag.
// The pivot, right-hand-side and upper stores need no clearing.
module tridiagonal_system_solver #(
  parameter int unsigned MAX_ROWS  = tss_pkg::MAX_ROWS_DEF,
  parameter int unsigned FRAC_BITS = tss_pkg::FRAC_BITS_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic signed [tss_pkg::FX_W-1:0]       sub_diag_i,
  input  logic signed [tss_pkg::FX_W-1:0]       main_diag_i,
  input  logic signed [tss_pkg::FX_W-1:0]       super_diag_i,
  input  logic signed [tss_pkg::FX_W-1:0]       rhs_value_i,
  input  logic                                  last_row_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic [tss_pkg::ROW_IDX_W-1:0]         row_index_o,
  output logic signed [tss_pkg::FX_W-1:0]       solution_o,
  output logic                                  singular_o,
  output logic                                  last_result_o
);

`include "tridiagonal_system_solver_defines.svh"

  localparam int unsigned W  = tss_pkg::FX_W;
  localparam int unsigned AW = $clog2(MAX_ROWS);
  localparam int unsigned PW = 2 * W;

  tss_pkg::tss_state_e state_q, state_d;

  logic [AW-1:0] row_cnt_q, row_cnt_d;
  logic [AW-1:0] k_q, k_d;
  logic          sing_q, sing_d;
  logic          first_q, first_d;

  // Row payload held for the forward step.
  logic signed [W-1:0] a_q, b_q, c_q, d_q;
  logic                fin_q;
  logic signed [W-1:0] piv_q, mr_q;
  logic signed [W-1:0] x_q;
  logic signed [PW-1:0] prod_q;

  logic signed [W-1:0] pivot_rd, mrhs_rd, upper_rd;
  logic                ram_re, ram_we;
  logic [AW-1:0]       ram_raddr;

  logic signed [W-1:0]  mul_a, mul_b;
  logic signed [PW-1:0] prod_full, prod_bias, prod_shr;
  logic signed [W-1:0]  scaled;

  logic                div_start, div_done;
  logic signed [W-1:0] div_num, div_quot;

  logic in_acc, out_acc, fin_in;

  assign in_ready_o  = (state_q == tss_pkg::S_IDLE);
  assign out_valid_o = (state_q == tss_pkg::S_OUT);
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_acc     = out_valid_o && out_ready_i;
  // The last slot of the stores closes a system even without last_row.
  assign fin_in      = last_row_i || (row_cnt_q == AW'(MAX_ROWS - 1));

  // Three stores share one address; the back pass reads them in step.
  tss_ram #(.WIDTH(W), .DEPTH(MAX_ROWS)) u_pivot_ram (
    .clk_i, .we_i(ram_we), .waddr_i(row_cnt_q), .wdata_i(piv_q),
    .re_i(ram_re), .raddr_i(ram_raddr), .rdata_o(pivot_rd)
  );
  tss_ram #(.WIDTH(W), .DEPTH(MAX_ROWS)) u_mrhs_ram (
    .clk_i, .we_i(ram_we), .waddr_i(row_cnt_q), .wdata_i(mr_q),
    .re_i(ram_re), .raddr_i(ram_raddr), .rdata_o(mrhs_rd)
  );
  tss_ram #(.WIDTH(W), .DEPTH(MAX_ROWS)) u_upper_ram (
    .clk_i, .we_i(ram_we), .waddr_i(row_cnt_q), .wdata_i(fin_q ? '0 : c_q),
    .re_i(ram_re), .raddr_i(ram_raddr), .rdata_o(upper_rd)
  );

  tss_div #(.FRAC(FRAC_BITS)) u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(div_num), .den_i(pivot_rd),
    .done_o(div_done), .quot_o(div_quot)
  );

  // Shared multiplier: operands picked by the sequencer step.
  always_comb begin
    unique case (state_q)
      tss_pkg::S_FMUL2: begin
        mul_a = a_q;
        mul_b = mrhs_rd;
      end
      tss_pkg::S_BMUL: begin
        mul_a = upper_rd;
        mul_b = x_q;
      end
      default: begin
        mul_a = a_q;
        mul_b = upper_rd;
      end
    endcase
    prod_full = mul_a * mul_b;
  end

  // Rescale the registered product: truncate toward zero, then clamp.
  always_comb begin
    prod_bias = prod_q + (prod_q[PW-1] ? PW'((64'd1 << FRAC_BITS) - 64'd1) : PW'(0));
    prod_shr  = prod_bias >>> FRAC_BITS;
    if (prod_shr > PW'(tss_pkg::FX_MAX)) begin
      scaled = tss_pkg::FX_MAX;
    end else if (prod_shr < PW'(tss_pkg::FX_MIN)) begin
      scaled = tss_pkg::FX_MIN;
    end else begin
      scaled = W'(prod_shr);
    end
    if ((state_q == tss_pkg::S_BDIVS) && !first_q) begin
      div_num = tss_pkg::sat_sub(mrhs_rd, scaled);
    end else if (state_q == tss_pkg::S_BDIVS) begin
      div_num = mrhs_rd;
    end else begin
      div_num = scaled;
    end
  end

  always_comb begin
    state_d   = state_q;
    row_cnt_d = row_cnt_q;
    k_d       = k_q;
    sing_d    = sing_q;
    first_d   = first_q;
    ram_re    = 1'b0;
    ram_we    = 1'b0;
    ram_raddr = k_q;
    div_start = 1'b0;
    unique case (state_q)
      tss_pkg::S_IDLE: begin
        if (in_acc) begin
          state_d = (row_cnt_q == '0) ? tss_pkg::S_FWR : tss_pkg::S_FRD;
        end
      end
      tss_pkg::S_FRD: begin
        ram_re    = 1'b1;
        ram_raddr = row_cnt_q - AW'(1);
        state_d   = tss_pkg::S_FMUL1;
      end
      tss_pkg::S_FMUL1:  state_d = tss_pkg::S_FDIV1S;
      tss_pkg::S_FDIV1S: begin
        div_start = 1'b1;
        state_d   = tss_pkg::S_FDIV1W;
      end
      tss_pkg::S_FDIV1W: if (div_done) state_d = tss_pkg::S_FMUL2;
      tss_pkg::S_FMUL2:  state_d = tss_pkg::S_FDIV2S;
      tss_pkg::S_FDIV2S: begin
        div_start = 1'b1;
        state_d   = tss_pkg::S_FDIV2W;
      end
      tss_pkg::S_FDIV2W: if (div_done) state_d = tss_pkg::S_FWR;
      tss_pkg::S_FWR: begin
        ram_we = 1'b1;
        if (piv_q == '0) sing_d = 1'b1;
        if (fin_q) begin
          k_d     = row_cnt_q;
          first_d = 1'b1;
          state_d = tss_pkg::S_BRD;
        end else begin
          row_cnt_d = row_cnt_q + AW'(1);
          state_d   = tss_pkg::S_IDLE;
        end
      end
      tss_pkg::S_BRD: begin
        ram_re  = 1'b1;
        state_d = tss_pkg::S_BMUL;
      end
      tss_pkg::S_BMUL:  state_d = tss_pkg::S_BDIVS;
      tss_pkg::S_BDIVS: begin
        div_start = 1'b1;
        state_d   = tss_pkg::S_BDIVW;
      end
      tss_pkg::S_BDIVW: if (div_done) state_d = tss_pkg::S_OUT;
      tss_pkg::S_OUT: begin
        if (out_acc) begin
          first_d = 1'b0;
          if (k_q == '0) begin
            // Row one delivered: drop the system, wait for a new one.
            row_cnt_d = '0;
            sing_d    = 1'b0;
            state_d   = tss_pkg::S_IDLE;
          end else begin
            k_d     = k_q - AW'(1);
            state_d = tss_pkg::S_BRD;
          end
        end
      end
      default: state_d = tss_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= tss_pkg::S_IDLE;
      row_cnt_q <= '0;
      k_q       <= '0;
      sing_q    <= 1'b0;
      first_q   <= 1'b0;
      x_q       <= '0;
    end else begin
      state_q   <= state_d;
      row_cnt_q <= row_cnt_d;
      k_q       <= k_d;
      sing_q    <= sing_d;
      first_q   <= first_d;
      if ((state_q == tss_pkg::S_BDIVW) && div_done) begin
        x_q <= div_quot;
      end
    end
  end

  // Datapath registers: hold the row, the product and the new pivot pair.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      a_q   <= sub_diag_i;
      b_q   <= main_diag_i;
      c_q   <= super_diag_i;
      d_q   <= rhs_value_i;
      fin_q <= fin_in;
      piv_q <= main_diag_i;
      mr_q  <= rhs_value_i;
    end
    if ((state_q == tss_pkg::S_FMUL1) || (state_q == tss_pkg::S_FMUL2) ||
        (state_q == tss_pkg::S_BMUL)) begin
      prod_q <= prod_full;
    end
    if ((state_q == tss_pkg::S_FDIV1W) && div_done) begin
      piv_q <= tss_pkg::sat_sub(b_q, div_quot);
    end
    if ((state_q == tss_pkg::S_FDIV2W) && div_done) begin
      mr_q <= tss_pkg::sat_sub(d_q, div_quot);
    end
  end

  assign row_index_o   = tss_pkg::ROW_IDX_W'(k_q) + tss_pkg::ROW_IDX_W'(1);
  assign solution_o    = x_q;
  assign singular_o    = sing_q;
  assign last_result_o = (k_q == '0);

  `TSS_ASSERT_IMPL(a_out_blocks_in, clk_i, rst_ni, out_valid_o, !in_ready_o)
  `TSS_ASSERT_IMPL(a_last_is_row_one, clk_i, rst_ni, out_valid_o && last_result_o,
                   row_index_o == tss_pkg::ROW_IDX_W'(1))
  `TSS_ASSERT_IMPL(a_div_done_waited, clk_i, rst_ni, div_done,
                   (state_q == tss_pkg::S_FDIV1W) || (state_q == tss_pkg::S_FDIV2W) ||
                   (state_q == tss_pkg::S_BDIVW))
  `TSS_ASSERT_NEXT(a_final_out_clears, clk_i, rst_ni, out_acc && last_result_o,
                   (row_cnt_q == '0) && !sing_q)

endmodule

>>> bench/tridiagonal_system_solver_test.sv
module tridiagonal_system_solver_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ROWS_MAX = tss_pkg::MAX_ROWS_DEF;
  localparam int unsigned FRAC     = tss_pkg::FRAC_BITS_DEF;
  localparam int unsigned FXW      = tss_pkg::FX_W;
  localparam int unsigned IDXW     = tss_pkg::ROW_IDX_W;
  // Longest silence: a forward row, or a result plus the longest receiver
  // stall; the limit takes it many times over.
  localparam int unsigned IDLE_LIMIT = 20000;
  localparam int unsigned DRAIN_CYCLES = 300;

  typedef logic signed [FXW-1:0] fx_t;

  typedef struct packed {
    logic [IDXW-1:0] row_index;
    fx_t             solution;
    logic            singular;
    logic            last_result;
  } solution_item_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  fx_t  sub_diag_i = '0;
  fx_t  main_diag_i = '0;
  fx_t  super_diag_i = '0;
  fx_t  rhs_value_i = '0;
  logic last_row_i = 1'b0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [IDXW-1:0] row_index_o;
  fx_t  solution_o;
  logic singular_o;
  logic last_result_o;

  always #2 clk_i = ~clk_i;

  tridiagonal_system_solver u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .sub_diag_i    (sub_diag_i),
    .main_diag_i   (main_diag_i),
    .super_diag_i  (super_diag_i),
    .rhs_value_i   (rhs_value_i),
    .last_row_i    (last_row_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .row_index_o   (row_index_o),
    .solution_o    (solution_o),
    .singular_o    (singular_o),
    .last_result_o (last_result_o)
  );

  // Solver shadow state: elimination stores, row count and singular flag.
  fx_t  pivot_q [ROWS_MAX];
  fx_t  mrhs_q  [ROWS_MAX];
  fx_t  upper_q [ROWS_MAX];
  int unsigned rows_held;
  logic singular_q;
  fx_t  back_x;

  solution_item_t pending_solutions[$];
  int unsigned mismatches;
  int unsigned rows_sent;
  int unsigned solutions_seen;
  int unsigned systems_solved;
  int unsigned idle_cycles;

  // Sender and receiver idle rates, in percent.
  int unsigned send_gap_pct;
  int unsigned recv_stall_pct;
  bit hold_off_recv;

  function automatic fx_t clamp_fx(longint v);
    if (v > longint'(tss_pkg::FX_MAX)) return tss_pkg::FX_MAX;
    if (v < longint'(tss_pkg::FX_MIN)) return tss_pkg::FX_MIN;
    return fx_t'(v);
  endfunction

  function automatic fx_t fx_times(fx_t p, fx_t q);
    longint prod;
    prod = longint'(p) * longint'(q);
    return clamp_fx(prod / (longint'(1) <<< FRAC));
  endfunction

  function automatic fx_t fx_over(fx_t p, fx_t q);
    if (q == 0) return '0;
    return clamp_fx((longint'(p) * (longint'(1) <<< FRAC)) / longint'(q));
  endfunction

  function automatic fx_t fx_minus(fx_t p, fx_t q);
    return clamp_fx(longint'(p) - longint'(q));
  endfunction

  // Eliminate one accepted row; on the final row queue the back-substituted
  // solutions, last row first.
  task automatic eliminate_row(fx_t a, fx_t b, fx_t c, fx_t d, logic fin);
    int unsigned i;
    int unsigned n;
    fx_t piv;
    fx_t mr;
    fx_t x;
    solution_item_t s;
    i = rows_held;
    if (i >= ROWS_MAX) i = ROWS_MAX - 1;
    if (i + 1 >= ROWS_MAX) fin = 1'b1;
    if (i == 0) begin
      piv = b;
      mr  = d;
    end else begin
      piv = fx_minus(b, fx_over(fx_times(a, upper_q[i-1]), pivot_q[i-1]));
      mr  = fx_minus(d, fx_over(fx_times(a, mrhs_q[i-1]), pivot_q[i-1]));
    end
    if (piv == 0) singular_q = 1'b1;
    pivot_q[i] = piv;
    mrhs_q[i]  = mr;
    upper_q[i] = fin ? fx_t'(0) : c;
    if (!fin) begin
      rows_held = i + 1;
      return;
    end
    n = i + 1;
    for (int k = n - 1; k >= 0; k--) begin
      if (k == n - 1) x = fx_over(mrhs_q[k], pivot_q[k]);
      else x = fx_over(fx_minus(mrhs_q[k], fx_times(upper_q[k], back_x)), pivot_q[k]);
      back_x = x;
      s.row_index   = IDXW'(k + 1);
      s.solution    = x;
      s.singular    = singular_q;
      s.last_result = (k == 0);
      pending_solutions.push_back(s);
    end
    systems_solved++;
    rows_held  = 0;
    singular_q = 1'b0;
  endtask

  task automatic report_mismatch(string what, longint got, longint want);
    $display("row item error: %s got %0d want %0d", what, got, want);
    mismatches++;
  endtask

  // Offer one row item; hold it until accepted. Valid stays high into the
  // next row unless the sender idles or waits for results.
  task automatic send_row(fx_t a, fx_t b, fx_t c, fx_t d, logic fin);
    if ($urandom_range(99) < send_gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < send_gap_pct) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    sub_diag_i   <= a;
    main_diag_i  <= b;
    super_diag_i <= c;
    rhs_value_i  <= d;
    last_row_i   <= fin;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    eliminate_row(a, b, c, d, fin);
    rows_sent++;
  endtask

  function automatic fx_t rand_fx();
    case ($urandom_range(9))
      0: return tss_pkg::FX_MAX;
      1: return tss_pkg::FX_MIN;
      2: return '0;
      3: return fx_t'($urandom);
      default: return fx_t'($urandom_range(0, 32'h0008_0000)) - fx_t'(32'h0004_0000);
    endcase
  endfunction

  // Diagonally dominant row with random content, so elimination stays sane.
  task automatic send_dominant_row(logic fin);
    fx_t a;
    fx_t c;
    fx_t b;
    a = fx_t'($urandom_range(0, 32'h0002_0000)) - fx_t'(32'h0001_0000);
    c = fx_t'($urandom_range(0, 32'h0002_0000)) - fx_t'(32'h0001_0000);
    b = fx_t'($urandom_range(32'h0003_0000, 32'h0008_0000));
    if ($urandom_range(1)) b = -b;
    send_row(a, b, c, fx_t'($urandom_range(0, 32'h0020_0000)) - fx_t'(32'h0010_0000), fin);
  endtask

  // Drop valid and hold until every expected result is in.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_solutions.size() != 0);
  endtask

  // Checker: compare each accepted solution item with the oldest expectation.
  always @(posedge clk_i) begin
    solution_item_t want;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o || out_valid_o && out_ready_i) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (out_valid_o && out_ready_i) begin
        solutions_seen++;
        if (pending_solutions.size() == 0) begin
          report_mismatch("unexpected item, row", row_index_o, -1);
        end else begin
          want = pending_solutions.pop_front();
          if (row_index_o !== want.row_index)
            report_mismatch("row_index", row_index_o, want.row_index);
          if (solution_o !== want.solution)
            report_mismatch("solution", solution_o, want.solution);
          if (singular_o !== want.singular)
            report_mismatch("singular", singular_o, want.singular);
          if (last_result_o !== want.last_result)
            report_mismatch("last_result", last_result_o, want.last_result);
        end
      end
    end
  end

  // Receiver: random stalls, or a long hold-off when asked.
  always @(posedge clk_i) begin
    if (hold_off_recv) out_ready_i <= 1'b0;
    else out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Watchdog on cycles where nothing moves.
  always @(posedge clk_i) begin
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout after %0d idle cycles", idle_cycles);
      $display("tridiagonal_system_solver: mismatch");
      $finish;
    end
  end

  // Extremes and special cases: single-row systems, zero pivot, saturation.
  task automatic test_directed();
    send_row(tss_pkg::FX_MAX, 32'sh0002_0000, tss_pkg::FX_MIN, 32'sh0006_0000, 1'b1);
    send_row('0, '0, '0, 32'sh0001_0000, 1'b1);
    send_row('0, 32'sh0000_0001, '0, tss_pkg::FX_MAX, 1'b1);
    send_row('0, tss_pkg::FX_MIN, '0, tss_pkg::FX_MIN, 1'b1);
    send_row(tss_pkg::FX_MIN, tss_pkg::FX_MAX, tss_pkg::FX_MAX, tss_pkg::FX_MIN, 1'b0);
    send_row(tss_pkg::FX_MIN, tss_pkg::FX_MIN, tss_pkg::FX_MAX, tss_pkg::FX_MAX, 1'b0);
    send_row(tss_pkg::FX_MAX, tss_pkg::FX_MAX, tss_pkg::FX_MIN, tss_pkg::FX_MIN, 1'b1);
    // Zero pivot in the middle of a system.
    send_row('0, 32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000, 1'b0);
    send_row(32'sh0001_0000, 32'sh0001_0000, 32'sh0002_0000, 32'sh0003_0000, 1'b0);
    send_row(32'sh0001_0000, 32'sh0004_0000, 32'sh7fff_0000, 32'sh0005_0000, 1'b1);
    // Classic second-difference system.
    for (int r = 0; r < 6; r++)
      send_row(-32'sh0001_0000, 32'sh0002_0000, -32'sh0001_0000, 32'sh0000_8000, r == 5);
    wait_drained();
  endtask

  // Full-length system: the last row ends it with last_row low.
  task automatic test_row_overflow();
    for (int r = 0; r < ROWS_MAX; r++) send_dominant_row(1'b0);
    wait_drained();
  endtask

  // Random systems, mostly small and well formed, some raw noise.
  task automatic test_random(int unsigned rows);
    int unsigned left;
    int unsigned len;
    left = rows;
    while (left > 0) begin
      len = ($urandom_range(19) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 6);
      if (len > left) len = left;
      for (int r = 0; r < len; r++) begin
        if ($urandom_range(4) == 0)
          send_row(rand_fx(), rand_fx(), rand_fx(), rand_fx(), r == len - 1);
        else send_dominant_row(r == len - 1);
      end
      left -= len;
    end
  endtask

  // Stall the receiver while the sender keeps offering systems.
  task automatic test_backpressure();
    hold_off_recv = 1'b1;
    fork
      begin
        repeat (400) @(posedge clk_i);
        hold_off_recv = 1'b0;
      end
      for (int s = 0; s < 3; s++)
        for (int r = 0; r < 3; r++) send_dominant_row(r == 2);
    join
    wait_drained();
  endtask

  initial begin
    mismatches = 0;
    rows_sent = 0;
    solutions_seen = 0;
    systems_solved = 0;
    idle_cycles = 0;
    rows_held = 0;
    singular_q = 1'b0;
    back_x = '0;
    hold_off_recv = 1'b0;
    send_gap_pct = 12;
    recv_stall_pct = 79;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_row_overflow();
    test_random(45);
    wait_drained();
    send_gap_pct = 79;
    recv_stall_pct = 12;
    test_random(45);
    test_backpressure();
    send_gap_pct = 0;
    recv_stall_pct = 0;
    test_random(45);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("covered %0d rows in %0d systems, %0d solutions checked", rows_sent,
             systems_solved, solutions_seen);
    $display("single-row, zero-pivot, saturating and full-length systems included");
    if (mismatches == 0) begin
      $display("tridiagonal_system_solver: match");
    end else begin
      $display("tridiagonal_system_solver: mismatch");
    end
    $finish;
  end

endmodule
